[rtl/core/bss_pkg.sv]
// Shared constants, types and helpers for the byte stream substring search block.
package bss_pkg;

   // Sizing
   localparam int MAX_PATTERN   = 16;
   localparam int OFFSET_BITS   = 16;
   localparam int WINDOW_DEPTH  = MAX_PATTERN;
   localparam int PATTERN_BYTES = 16;
   localparam int SEL_W         = $clog2(PATTERN_BYTES);
   localparam int CELL_IDX_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int LEN_W         = 5;
   localparam int CNT_W         = OFFSET_BITS + 1;
   localparam int OFFSET_W      = 16;
   localparam int CMP_W         = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W + 1;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH   = CSR_IDX_W'(2);

   typedef logic [7:0]                    byte_type;
   typedef logic [PATTERN_BYTES-1:0][7:0] pattern_type;
   typedef logic [LEN_W-1:0]              len_type;
   typedef logic [CNT_W-1:0]              count_type;
   typedef logic [OFFSET_W-1:0]           offset_type;

   // Per-cycle control for the window cells
   typedef struct packed {
      logic advance;
      logic clear;
   } cell_ctrl_type;

   // Result word
   typedef struct packed {
      logic       found;
      offset_type match_offset;
      logic       offset_overflow;
   } rsp_word_type;

   // Clamp a raw length into 1..MAX_PATTERN
   function automatic len_type effective_length(input len_type raw);
      len_type len;
      len = raw;
      if (raw == '0) begin
         len = LEN_W'(1);
      end else if (raw > LEN_W'(MAX_PATTERN)) begin
         len = LEN_W'(MAX_PATTERN);
      end
      return len;
   endfunction

endpackage

[rtl/core/bss_if.sv]
// Channel interfaces: haystack byte input, result output and register write port.
interface bss_req_if;
   logic               valid;
   logic               ready;
   bss_pkg::byte_type  data_byte;
   logic               last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bss_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 found;
   bss_pkg::offset_type  match_offset;
   logic                 offset_overflow;

   modport source (output valid, output found, output match_offset,
                   output offset_overflow, input ready);
   modport sink   (input valid, input found, input match_offset,
                   input offset_overflow, output ready);
endinterface

interface bss_csr_if;
   logic                                valid;
   logic                                ready;
   logic [bss_pkg::CSR_IDX_W-1:0]       index;
   logic [bss_pkg::CSR_DATA_W-1:0]      write_data;

   modport source (output valid, output index, output write_data, input ready);
   modport sink   (input valid, input index, input write_data, output ready);
endinterface

[rtl/core/bss_cell.sv]
// One window cell: holds one past byte and compares its incoming byte with its pattern byte.
module bss_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  bss_pkg::cell_ctrl_type             ctrl,
   input  logic [bss_pkg::CELL_IDX_W-1:0]     cell_idx,
   input  bss_pkg::byte_type                  byte_in,
   input  bss_pkg::pattern_type               pattern,
   input  bss_pkg::len_type                   len,
   output bss_pkg::byte_type                  byte_out,
   output logic                               hit
);

   bss_pkg::byte_type                 window_ff;
   bss_pkg::byte_type                 window_in;
   logic [bss_pkg::SEL_W-1:0]         sel;
   logic                              active;

   // Cell j sees the byte j steps back, which lines up with pattern byte len-1-j
   assign active = bss_pkg::LEN_W'(cell_idx) < len;
   assign sel    = bss_pkg::SEL_W'(len - bss_pkg::LEN_W'(1) - bss_pkg::LEN_W'(cell_idx));
   assign hit    = !active || (byte_in == pattern[sel]);

   // Shift in, clear on rearm, hold otherwise
   always_comb begin
      window_in = window_ff;
      if (ctrl.clear) begin
         window_in = '0;
      end else if (ctrl.advance) begin
         window_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

   assign byte_out = window_ff;

endmodule

[rtl/core/bss_chain.sv]
// Row of window cells; reports a full match across the active pattern length.
module bss_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  bss_pkg::cell_ctrl_type  ctrl,
   input  bss_pkg::byte_type       byte_in,
   input  bss_pkg::pattern_type    pattern,
   input  bss_pkg::len_type        len,
   output logic                    all_hit
);

   bss_pkg::byte_type                    link [bss_pkg::WINDOW_DEPTH];
   logic [bss_pkg::WINDOW_DEPTH-1:0]     hit;

   assign link[0] = byte_in;

   // Each cell feeds its stored byte to the next one
   for (genvar j = 0; j < bss_pkg::WINDOW_DEPTH; j++) begin : g_cell
      if (j < bss_pkg::WINDOW_DEPTH - 1) begin : g_mid
         bss_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .cell_idx (bss_pkg::CELL_IDX_W'(j)),
            .byte_in  (link[j]),
            .pattern  (pattern),
            .len      (len),
            .byte_out (link[j+1]),
            .hit      (hit[j])
         );
      end else begin : g_end
         bss_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .cell_idx (bss_pkg::CELL_IDX_W'(j)),
            .byte_in  (link[j]),
            .pattern  (pattern),
            .len      (len),
            .byte_out (),
            .hit      (hit[j])
         );
      end
   end

   assign all_hit = &hit;

endmodule

[rtl/core/bss_out_skid.sv]
// Output register with one skid word; the input side waits on the consumer only while the skid word is held.
module bss_out_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  bss_pkg::rsp_word_type  push_word,
   output logic                   can_take,
   bss_rsp_if.source              rsp_ch
);

   logic                   out_valid_ff;
   logic                   out_valid_in;
   bss_pkg::rsp_word_type  out_word_ff;
   bss_pkg::rsp_word_type  out_word_in;
   logic                   skid_valid_ff;
   logic                   skid_valid_in;
   bss_pkg::rsp_word_type  skid_word_ff;
   bss_pkg::rsp_word_type  skid_word_in;
   logic                   pop;

   assign pop      = out_valid_ff && rsp_ch.ready;
   assign can_take = !skid_valid_ff;

   // Refill from skid first, else load the new word or park it in the skid
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_word_in   = out_word_ff;
      skid_valid_in = skid_valid_ff;
      skid_word_in  = skid_word_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_word_in   = skid_word_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_word_in  = push_word;
            out_valid_in = 1'b1;
         end else begin
            skid_word_in  = push_word;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.found           = out_word_ff.found;
   assign rsp_ch.match_offset    = out_word_ff.match_offset;
   assign rsp_ch.offset_overflow = out_word_ff.offset_overflow;

   // Skid only ever holds a word behind a full output register
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid word held with empty output register");

   // A word pushed into a stalled output must land in the skid
   a_stall_parks: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready && push && !skid_valid_ff |=> skid_valid_ff)
      else $error("word lost while output stalled");

   // No push arrives while the skid is occupied
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("push while skid full");

endmodule

[rtl/core/byte_stream_substring_search.sv]
// Top level: pattern registers, byte counter, match report and rearm control.
//
//   channel   dir   handshake      word
//   req_ch    in    valid/ready    data_byte, last_byte
//   rsp_ch    out   valid/ready    found, match_offset, offset_overflow
//   csr_ch    in    valid/ready    index, write_data (ready always high)
//
// One byte per cycle while req_ch.ready is high; each result word is registered on its way to rsp_ch.
// The compare of all window cells and the offset subtract sit in one stage before the
// output register. Synchronous reset takes effect at once; no clearing pass.
// req_ch.ready drops only while both the output register and its skid word are held.
module byte_stream_substring_search (
   input  logic        clock,
   input  logic        reset,
   bss_req_if.sink     req_ch,
   bss_rsp_if.source   rsp_ch,
   bss_csr_if.sink     csr_ch
);

   bss_pkg::len_type                      len_ff;
   bss_pkg::len_type                      len_in;
   logic [bss_pkg::CSR_DATA_W-1:0]        pat_low_ff;
   logic [bss_pkg::CSR_DATA_W-1:0]        pat_low_in;
   logic [bss_pkg::CSR_DATA_W-1:0]        pat_high_ff;
   logic [bss_pkg::CSR_DATA_W-1:0]        pat_high_in;
   bss_pkg::count_type                    count_ff;
   bss_pkg::count_type                    count_in;
   logic                                  reported_ff;
   logic                                  reported_in;

   bss_pkg::pattern_type                  pattern;
   bss_pkg::cell_ctrl_type                cell_ctrl;
   bss_pkg::count_type                    count_step;
   bss_pkg::count_type                    off_raw;
   bss_pkg::rsp_word_type                 push_word;
   logic                                  csr_wr;
   logic                                  accept;
   logic                                  searching;
   logic                                  saturated;
   logic                                  enough;
   logic                                  all_hit;
   logic                                  match;
   logic                                  clamp;
   logic                                  push;
   logic                                  can_take;

   // Register writes
   assign csr_ch.ready = 1'b1;
   assign csr_wr       = csr_ch.valid && csr_ch.ready;

   always_comb begin
      len_in      = len_ff;
      pat_low_in  = pat_low_ff;
      pat_high_in = pat_high_ff;
      if (csr_wr) begin
         unique case (csr_ch.index)
            bss_pkg::CSR_PATTERN_LENGTH: begin
               len_in = bss_pkg::effective_length(csr_ch.write_data[bss_pkg::LEN_W-1:0]);
            end
            bss_pkg::CSR_PATTERN_LOW: begin
               pat_low_in = csr_ch.write_data;
            end
            bss_pkg::CSR_PATTERN_HIGH: begin
               pat_high_in = csr_ch.write_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign pattern = bss_pkg::pattern_type'({pat_high_ff, pat_low_ff});

   // Byte acceptance and window control
   assign accept    = req_ch.valid && req_ch.ready;
   assign searching = accept && !reported_ff;
   assign req_ch.ready = can_take;

   assign cell_ctrl.advance = searching;
   assign cell_ctrl.clear   = accept && req_ch.last_byte;

   bss_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (cell_ctrl),
      .byte_in (req_ch.data_byte),
      .pattern (pattern),
      .len     (len_ff),
      .all_hit (all_hit)
   );

   // Count bytes, saturating at the top of the offset range
   assign saturated  = count_ff[bss_pkg::OFFSET_BITS];
   assign count_step = saturated ? count_ff : count_ff + bss_pkg::CNT_W'(1);
   assign enough     = count_step >= bss_pkg::CNT_W'(len_ff);
   assign match      = searching && enough && all_hit;

   // Start offset of the match, clamped to the field
   assign off_raw = count_step - bss_pkg::CNT_W'(len_ff);
   assign clamp   = saturated ||
                    (bss_pkg::CMP_W'(off_raw) > bss_pkg::CMP_W'({bss_pkg::OFFSET_W{1'b1}}));

   assign push = searching && (match || req_ch.last_byte);

   always_comb begin
      push_word.found           = match;
      push_word.match_offset    = '0;
      push_word.offset_overflow = count_step[bss_pkg::OFFSET_BITS];
      if (match) begin
         push_word.match_offset    = clamp ? '1 : bss_pkg::OFFSET_W'(off_raw);
         push_word.offset_overflow = clamp;
      end
   end

   // Advance count and report flag; rearm on the last byte
   always_comb begin
      count_in    = count_ff;
      reported_in = reported_ff;
      if (accept && req_ch.last_byte) begin
         count_in    = '0;
         reported_in = 1'b0;
      end else if (searching) begin
         count_in    = count_step;
         reported_in = match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= bss_pkg::LEN_W'(1);
         pat_low_ff  <= '0;
         pat_high_ff <= '0;
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else begin
         len_ff      <= len_in;
         pat_low_ff  <= pat_low_in;
         pat_high_ff <= pat_high_in;
         count_ff    <= count_in;
         reported_ff <= reported_in;
      end
   end

   bss_out_skid u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .can_take  (can_take),
      .rsp_ch    (rsp_ch)
   );

   // The last byte rearms the search
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      accept && req_ch.last_byte |=> (count_ff == '0) && !reported_ff)
      else $error("search not rearmed after last byte");

   // Counter never runs past saturation
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (bss_pkg::count_type'(1) << bss_pkg::OFFSET_BITS))
      else $error("byte counter beyond saturation");

   // Once a match is reported the haystack stays silent
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      reported_ff |-> !push)
      else $error("second result in one haystack");

endmodule

[tb/tb_byte_stream_substring_search.sv]
// Testbench for the byte stream substring search block, checked against a cycle-free predictor.
`timescale 1ns / 1ps

module tb_byte_stream_substring_search;

   localparam int HALF_PERIOD  = 1;
   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_BYTES = 1530;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_LIMIT   = 3000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PRINT_LIMIT  = 40;

   localparam bss_pkg::count_type COUNT_SAT =
      bss_pkg::count_type'(1) << bss_pkg::OFFSET_BITS;
   localparam logic [bss_pkg::CSR_IDX_W-1:0] CSR_UNUSED = bss_pkg::CSR_IDX_W'(3);

   // Predicts result words from accepted bytes and checks the words that come out
   class substring_scoreboard;
      bss_pkg::byte_type     window [bss_pkg::WINDOW_DEPTH];
      bss_pkg::count_type    byte_count;
      bit                    reported;
      bss_pkg::len_type      raw_length;
      logic [127:0]          pattern;
      bss_pkg::rsp_word_type pending_results [$];
      int unsigned           errors;
      int unsigned           found_seen;
      int unsigned           missed_seen;
      int unsigned           overflow_seen;
      int unsigned           haystacks;
      int unsigned           bytes_seen;
      int unsigned           reg_writes;

      function new();
         raw_length = bss_pkg::len_type'(1);
         pattern    = '0;
         rearm();
      endfunction

      function void rearm();
         foreach (window[i]) window[i] = '0;
         byte_count = '0;
         reported   = 1'b0;
      endfunction

      function void write_reg(logic [bss_pkg::CSR_IDX_W-1:0] index,
                              logic [bss_pkg::CSR_DATA_W-1:0] data);
         reg_writes++;
         case (index)
            bss_pkg::CSR_PATTERN_LENGTH: raw_length = data[bss_pkg::LEN_W-1:0];
            bss_pkg::CSR_PATTERN_LOW:    pattern[63:0] = data;
            bss_pkg::CSR_PATTERN_HIGH:   pattern[127:64] = data;
            default: ;
         endcase
      endfunction

      // Zero counts as one byte, anything past the window as a full window
      function int unsigned active_length();
         if (raw_length == '0) return 1;
         if (raw_length > bss_pkg::MAX_PATTERN) return bss_pkg::MAX_PATTERN;
         return raw_length;
      endfunction

      function void predict_byte(bss_pkg::byte_type data, logic last);
         int unsigned           len;
         int unsigned           pos;
         int unsigned           offset;
         int unsigned           k;
         bit                    saturated;
         bit                    hit;
         bss_pkg::rsp_word_type word;
         bytes_seen++;
         if (!reported) begin
            len       = active_length();
            pos       = byte_count;
            saturated = (byte_count >= COUNT_SAT);
            for (k = bss_pkg::WINDOW_DEPTH - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = data;
            if (!saturated) byte_count++;

            // compare oldest window byte against pattern byte 0
            hit = (byte_count >= len);
            for (k = 0; k < len; k++) begin
               if (window[len-1-k] != pattern[8*k +: 8]) hit = 1'b0;
            end

            if (hit) begin
               offset               = saturated ? 32'hFFFF : pos - (len - 1);
               word.found           = 1'b1;
               word.offset_overflow = saturated;
               if (offset > 32'hFFFF) begin
                  offset               = 32'hFFFF;
                  word.offset_overflow = 1'b1;
               end
               word.match_offset = bss_pkg::OFFSET_W'(offset);
               reported          = 1'b1;
               pending_results.push_back(word);
            end else if (last) begin
               word.found           = 1'b0;
               word.match_offset    = '0;
               word.offset_overflow = (byte_count >= COUNT_SAT);
               pending_results.push_back(word);
            end
         end
         if (last) begin
            rearm();
            haystacks++;
         end
      endfunction

      task report_mismatch(string line);
         errors++;
         if (errors <= PRINT_LIMIT) $display("%0t ns: %s", $time, line);
      endtask

      task check_result(bss_pkg::rsp_word_type got);
         bss_pkg::rsp_word_type want;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected word found=%0d offset=%0d overflow=%0d",
                                      got.found, got.match_offset, got.offset_overflow));
            return;
         end
         want = pending_results.pop_front();
         if (got.found) found_seen++;
         else missed_seen++;
         if (got.offset_overflow) overflow_seen++;
         if (got.found !== want.found)
            report_mismatch($sformatf("found: got %0d, expected %0d", got.found, want.found));
         if (got.match_offset !== want.match_offset)
            report_mismatch($sformatf("match_offset: got %0d, expected %0d",
                                      got.match_offset, want.match_offset));
         if (got.offset_overflow !== want.offset_overflow)
            report_mismatch($sformatf("offset_overflow: got %0d, expected %0d",
                                      got.offset_overflow, want.offset_overflow));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   gaps_on = 1'b1;
   bit   hold_rsp = 1'b0;
   int unsigned idle_cycles;

   bss_req_if req_ch ();
   bss_rsp_if rsp_ch ();
   bss_csr_if csr_ch ();

   substring_scoreboard board = new();

   byte_stream_substring_search i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #HALF_PERIOD clock = ~clock;

   // Watch all three channels; predict, check, and stop on a long silence
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            board.predict_byte(req_ch.data_byte, req_ch.last_byte);
         if (csr_ch.valid && csr_ch.ready)
            board.write_reg(csr_ch.index, csr_ch.write_data);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result({rsp_ch.found, rsp_ch.match_offset, rsp_ch.offset_overflow});
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Result side: random back-pressure, or a long hold-off when asked
   initial begin : rsp_side
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp_ch.ready <= gaps_on ? ($urandom_range(99) >= 30) : 1'b1;
         end
      end
   end

   // Offer one byte, idling at random first; return at the falling edge after acceptance
   task automatic send_byte(bss_pkg::byte_type data, logic last);
      while (gaps_on && $urandom_range(99) < 30) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= data;
      req_ch.last_byte <= last;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   task automatic send_haystack(bss_pkg::byte_type hay[$]);
      foreach (hay[i]) send_byte(hay[i], i == hay.size() - 1);
   endtask

   task automatic write_csr(logic [bss_pkg::CSR_IDX_W-1:0] index,
                            logic [bss_pkg::CSR_DATA_W-1:0] data);
      csr_ch.valid      <= 1'b1;
      csr_ch.index      <= index;
      csr_ch.write_data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
   endtask

   // Write length (junk above the length bits), both pattern halves, maybe the unused index
   task automatic load_pattern(logic [bss_pkg::LEN_W-1:0] raw_len, logic [127:0] pat,
                               bit spare);
      logic [bss_pkg::CSR_DATA_W-1:0] len_word;
      len_word = {$urandom, $urandom};
      len_word[bss_pkg::LEN_W-1:0] = raw_len;
      write_csr(bss_pkg::CSR_PATTERN_LENGTH, len_word);
      write_csr(bss_pkg::CSR_PATTERN_LOW, pat[63:0]);
      write_csr(bss_pkg::CSR_PATTERN_HIGH, pat[127:64]);
      if (spare) write_csr(CSR_UNUSED, {$urandom, $urandom});
      csr_ch.valid <= 1'b0;
   endtask

   // Drop valid, wait for every expected word, then let the pipe settle
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (board.pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned       phase;
      int unsigned       raw_len;
      int unsigned       sel;
      int unsigned       eff;
      int unsigned       kind;
      int unsigned       hay_len;
      int unsigned       plant_at;
      int unsigned       n_hay;
      int unsigned       random_bytes;
      logic [127:0]      pat;
      bss_pkg::byte_type base;
      bss_pkg::byte_type hay [$];

      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.data_byte  = '0;
      req_ch.last_byte  = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = '0;
      csr_ch.write_data = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset pattern is a single zero byte
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      wait_drained();

      // Full-width all-ones pattern, matched on the last byte
      load_pattern(5'd16, '1, 1'b0);
      for (int i = 0; i < 16; i++) send_byte(8'hFF, i == 15);
      wait_drained();

      // Zero length acts as one; bytes after the match give nothing
      load_pattern(5'd0, {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF5A}, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h80, 1'b1);
      wait_drained();

      // Oversize length acts as full window; a short haystack misses
      load_pattern(5'd31, '1, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_drained();

      // Random phases: new setting, then a batch of mostly well-formed haystacks
      phase        = 0;
      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         phase++;
         sel = $urandom_range(99);
         if (phase == 2) raw_len = 1;
         else if (sel < 45) raw_len = $urandom_range(1, 4);
         else if (sel < 75) raw_len = $urandom_range(5, 15);
         else if (sel < 88) raw_len = 16;
         else if (sel < 94) raw_len = 0;
         else raw_len = $urandom_range(17, 31);

         sel = $urandom_range(99);
         if (sel < 10) begin
            pat = '0;
         end else if (sel < 20) begin
            pat = '1;
         end else if (sel < 60) begin
            base = bss_pkg::byte_type'($urandom);
            for (int i = 0; i < 16; i++)
               pat[8*i +: 8] = base + bss_pkg::byte_type'($urandom_range(0, 2));
         end else begin
            pat = {$urandom, $urandom, $urandom, $urandom};
         end
         load_pattern(bss_pkg::LEN_W'(raw_len), pat, $urandom_range(9) == 0);
         eff = board.active_length();

         // Phase two fills the block behind a stalled receiver
         if (phase == 2) hold_rsp = 1'b1;
         // Phase three runs with no idling on either side
         gaps_on = (phase != 3);
         if (phase == 2) n_hay = 40;
         else if (phase == 3) n_hay = 20;
         else n_hay = $urandom_range(4, 10);
         repeat (n_hay) begin
            hay.delete();
            kind = $urandom_range(99);
            if (kind < 15) begin
               hay_len = $urandom_range(1, eff);
               for (int i = 0; i < hay_len; i++)
                  hay.push_back(pat[8*$urandom_range(0, eff - 1) +: 8]);
            end else if (kind < 30) begin
               hay_len = $urandom_range(1, 40);
               for (int i = 0; i < hay_len; i++) hay.push_back(bss_pkg::byte_type'($urandom));
            end else begin
               hay_len = $urandom_range(eff, eff + 30);
               for (int i = 0; i < hay_len; i++) begin
                  if ($urandom_range(99) < 70) hay.push_back(pat[8*$urandom_range(0, eff - 1) +: 8]);
                  else hay.push_back(bss_pkg::byte_type'($urandom));
               end
               if ($urandom_range(1)) begin
                  plant_at = $urandom_range(0, hay_len - eff);
                  for (int i = 0; i < eff; i++) hay[plant_at + i] = pat[8*i +: 8];
               end
            end
            send_haystack(hay);
            random_bytes += hay.size();
         end
         wait_drained();
         gaps_on = 1'b1;
      end

      $display("Ran %0d haystacks, %0d bytes, %0d register writes over %0d random settings.",
               board.haystacks, board.bytes_seen, board.reg_writes, phase);
      $display("Saw %0d matches, %0d misses, %0d with offset overflow; %0d mismatches.",
               board.found_seen, board.missed_seen, board.overflow_seen, board.errors);
      if (board.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/bss_pkg.sv
rtl/core/bss_if.sv
rtl/core/bss_cell.sv
rtl/core/bss_chain.sv
rtl/core/bss_out_skid.sv
rtl/core/byte_stream_substring_search.sv
tb/tb_byte_stream_substring_search.sv
